[rtl/assert_macros.svh]
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, quiet in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vssd_pkg.sv]
package vssd_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_STORED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SORTED    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RM_SCAN,
        ST_COPY,
        ST_SORT,
        ST_EMIT,
        ST_RESP
    } t_state;

endpackage

[rtl/value_store_sorted_dump.sv]
// Bounded store of signed 32-bit values, driven by one input stream and
// answered on one output stream.
// Input beat: tuser = action (0 push, 1 remove first equal, 2 dump sorted,
// 3 ignored), tdata = value. Output beat: tdata = value, position, count;
// tuser = status, empty-dump flag; tlast marks the final beat of an item.
// Entries sit in one single-port-read RAM in insertion order; a dump copies
// them into a second RAM and sorts there, so the store is left untouched.
// Per item:
//   push             stores the value unless full, one result
//   remove           one RAM walk that searches and shifts later entries
//                    down, skipped when empty, one result
//   dump             one result when empty, else a copy of the entries into
//                    the second RAM, then one pass per rank, each ending in
//                    one result
// A new item is taken only between items; a result may still sit in the
// output register when the next item is accepted.
// If the receiver stalls, the output register holds its beat and the block
// waits before producing the next one; nothing is dropped.
// Reset empties the store (count to zero) and clears any pending beat; the
// RAM contents are not cleared and need no clearing pass.
module value_store_sorted_dump #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] result_value, [37:32] position,
                                          // [44:38] entry_count, zero above
    output logic [3:0]  o_m_axis_tuser,   // [2:0] status, [3] empty_dump
    output logic        o_m_axis_tlast
);
    import vssd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VAL_W-1:0] entry_ram [DEPTH];
    logic signed [VAL_W-1:0] work_ram  [DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic r_rd_vld, n_rd_vld;
    logic r_rd_first, n_rd_first;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic r_found, n_found;
    logic [AW-1:0] r_pos, n_pos;
    logic signed [VAL_W-1:0] r_cur, n_cur;
    logic [AW-1:0] r_rank, n_rank;
    logic signed [VAL_W-1:0] r_value, n_value;

    logic signed [VAL_W-1:0] r_res_val, n_res_val;
    logic [AW-1:0] r_res_pos, n_res_pos;
    logic [STAT_W-1:0] r_res_st, n_res_st;
    logic [CW-1:0] r_res_cnt, n_res_cnt;
    logic r_res_empty, n_res_empty;

    logic r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_val, n_out_val;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic [STAT_W-1:0] r_out_st, n_out_st;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic r_out_empty, n_out_empty;
    logic r_out_last, n_out_last;

    logic signed [VAL_W-1:0] r_ent_q, r_work_q;

    logic ent_re, work_re, ent_we, work_we;
    logic [AW-1:0] ent_wa, work_wa;
    logic signed [VAL_W-1:0] ent_wd, work_wd;
    logic in_acc, out_free, rd_more;

    // RAMs: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            entry_ram[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            r_ent_q <= entry_ram[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            work_ram[work_wa] <= work_wd;
        end
        if (work_re) begin
            r_work_q <= work_ram[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rd_first  <= n_rd_first;
        r_rd_idx    <= n_rd_idx;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_cur       <= n_cur;
        r_rank      <= n_rank;
        r_value     <= n_value;
        r_res_val   <= n_res_val;
        r_res_pos   <= n_res_pos;
        r_res_st    <= n_res_st;
        r_res_cnt   <= n_res_cnt;
        r_res_empty <= n_res_empty;
        r_out_val   <= n_out_val;
        r_out_pos   <= n_out_pos;
        r_out_st    <= n_out_st;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_first  = r_rd_first;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_rank      = r_rank;
        n_value     = r_value;
        n_res_val   = r_res_val;
        n_res_pos   = r_res_pos;
        n_res_st    = r_res_st;
        n_res_cnt   = r_res_cnt;
        n_res_empty = r_res_empty;
        n_out_val   = r_out_val;
        n_out_pos   = r_out_pos;
        n_out_st    = r_out_st;
        n_out_cnt   = r_out_cnt;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;

        ent_re  = 1'b0;
        work_re = 1'b0;
        ent_we  = 1'b0;
        work_we = 1'b0;
        ent_wa  = r_fill[AW-1:0];
        ent_wd  = r_value;
        work_wa = r_rd_idx;
        work_wd = r_ent_q;

        out_free = !r_out_valid || i_m_axis_tready;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        o_s_axis_tready = (r_state == ST_IDLE);
        in_acc  = i_s_axis_tvalid && o_s_axis_tready;
        rd_more = (r_idx < r_fill);

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_value = $signed(i_s_axis_tdata);
                    n_res_val = $signed(i_s_axis_tdata);
                    n_res_empty = 1'b0;
                    n_res_pos = '0;
                    n_idx = '0;
                    n_found = 1'b0;
                    unique case (i_s_axis_tuser)
                        ACT_PUSH: begin
                            if (r_fill < CW'(DEPTH)) begin
                                ent_we = 1'b1;
                                ent_wa = r_fill[AW-1:0];
                                ent_wd = $signed(i_s_axis_tdata);
                                n_fill = r_fill + CW'(1);
                                n_res_pos = r_fill[AW-1:0];
                                n_res_st = STAT_STORED;
                                n_res_cnt = r_fill + CW'(1);
                            end else begin
                                n_res_st = STAT_FULL;
                                n_res_cnt = r_fill;
                            end
                            n_state = ST_RESP;
                        end
                        ACT_REMOVE: begin
                            n_res_st = STAT_NOT_FOUND;
                            n_res_cnt = r_fill;
                            n_state = (r_fill == '0) ? ST_RESP : ST_RM_SCAN;
                        end
                        ACT_DUMP: begin
                            if (r_fill == '0) begin
                                n_res_val = '0;
                                n_res_st = STAT_SORTED;
                                n_res_cnt = '0;
                                n_res_empty = 1'b1;
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_COPY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RM_SCAN: begin
                if (rd_more) begin
                    ent_re = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                    n_idx = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (r_found) begin
                        // close the gap behind the removed entry
                        ent_we = 1'b1;
                        ent_wa = r_rd_idx - AW'(1);
                        ent_wd = r_ent_q;
                    end else if (r_ent_q == r_value) begin
                        n_found = 1'b1;
                        n_pos = r_rd_idx;
                    end
                end
                if (!rd_more && !r_rd_vld) begin
                    if (r_found) begin
                        n_fill = r_fill - CW'(1);
                        n_res_st = STAT_REMOVED;
                        n_res_pos = r_pos;
                        n_res_cnt = r_fill - CW'(1);
                    end
                    n_state = ST_RESP;
                end
            end
            ST_COPY: begin
                if (rd_more) begin
                    ent_re = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                    n_idx = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    work_we = 1'b1;
                    work_wa = r_rd_idx;
                    work_wd = r_ent_q;
                end
                if (!rd_more && !r_rd_vld) begin
                    n_rank = '0;
                    n_idx = '0;
                    n_rd_first = 1'b1;
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                // one exchange pass: r_cur ends up the smallest from rank on
                if (rd_more) begin
                    work_re = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                    n_idx = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    n_rd_first = 1'b0;
                    if (r_rd_first) begin
                        n_cur = r_work_q;
                    end else if (r_cur > r_work_q) begin
                        work_we = 1'b1;
                        work_wa = r_rd_idx;
                        work_wd = r_cur;
                        n_cur = r_work_q;
                    end
                end
                if (!rd_more && !r_rd_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val = r_cur;
                    n_out_pos = POS_W'(r_rank);
                    n_out_st = STAT_SORTED;
                    n_out_cnt = CNT_W'(r_fill);
                    n_out_empty = 1'b0;
                    n_out_last = (CW'(r_rank) + CW'(1) == r_fill);
                    if (CW'(r_rank) + CW'(1) == r_fill) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rank = r_rank + AW'(1);
                        n_idx = CW'(r_rank) + CW'(1);
                        n_rd_first = 1'b1;
                        n_state = ST_SORT;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val = r_res_val;
                    n_out_pos = POS_W'(r_res_pos);
                    n_out_st = r_res_st;
                    n_out_cnt = CNT_W'(r_res_cnt);
                    n_out_empty = r_res_empty;
                    n_out_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_cnt, r_out_pos, r_out_val};
    assign o_m_axis_tuser  = {r_out_empty, r_out_st};
    assign o_m_axis_tlast  = r_out_last;

endmodule

[rtl/vssd_checker.sv]
`include "assert_macros.svh"

module vssd_checker #(
    parameter int DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import vssd_pkg::*;

    logic out_stall;
    logic single_kind;
    logic [6:0] out_cnt;
    logic [5:0] out_pos;

    assign out_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_cnt     = o_m_axis_tdata[44:38];
    assign out_pos     = o_m_axis_tdata[37:32];
    assign single_kind = (o_m_axis_tuser[2:0] == STAT_STORED)
                      || (o_m_axis_tuser[2:0] == STAT_FULL)
                      || (o_m_axis_tuser[2:0] == STAT_REMOVED)
                      || (o_m_axis_tuser[2:0] == STAT_NOT_FOUND);

    // a stalled beat stays put
    `ASSERT_NEXT(a_out_hold, out_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast), "output beat changed while stalled")

    // push and remove answer with exactly one beat
    `ASSERT_IMPL(a_single_last, o_m_axis_tvalid && single_kind, o_m_axis_tlast,
        "push or remove result without tlast")

    // an empty dump is a lone sorted beat with nothing stored
    `ASSERT_IMPL(a_empty_dump, o_m_axis_tvalid && o_m_axis_tuser[3],
        o_m_axis_tlast && (o_m_axis_tuser[2:0] == STAT_SORTED) && (out_cnt == 7'd0),
        "malformed empty dump beat")

    // on sorted beats, count stays within capacity and ranks stay below the count
    `ASSERT_IMPL(a_rank_range, o_m_axis_tvalid && (o_m_axis_tuser[2:0] == STAT_SORTED)
        && !o_m_axis_tuser[3],
        (7'(out_pos) < out_cnt) && (out_cnt <= 7'(DEPTH)),
        "sorted rank or count out of range")

endmodule

bind value_store_sorted_dump vssd_checker #(.DEPTH(DEPTH)) u_vssd_checker (.*);
